@@ rtl/amp_offset_cal_encoder_top_defines.svh @@
// Assertion macros used by the top level of the offset calibration encoder.
`ifndef AMP_OFFSET_CAL_ENCODER_TOP_DEFINES_SVH
`define AMP_OFFSET_CAL_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define AOCE_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked during reset as well.
`define AOCE_ASSERT_NEXT(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/aoce_pkg.sv @@
// Types, constants and the step lookup table of the offset calibration encoder.
`default_nettype none

package aoce_pkg;

    localparam int MAG_W   = 23;
    localparam int STEP_W  = 11;
    localparam int VLSB_W  = 15;
    localparam int BOUND_W = 22;
    localparam int Q_W     = 7;
    localparam int PROD_W  = Q_W + VLSB_W;
    localparam int NUM_RANGES = 4;

    localparam int BASE_STEP_UV = 126;
    localparam int COEFF_SCALE  = 1000;
    localparam int GAIN_DIV [6] = '{1333, 2301, 4283, 8289, 16311, 31599};

    localparam logic [1:0] BIAS_BANDGAP  = 2'd1;
    localparam logic [1:0] BIAS_SUPPLY   = 2'd2;
    localparam logic [3:0] BANDGAP_VOLTS = 4'd5;
    localparam logic [2:0] GAIN_UNITY    = 3'd0;

    typedef enum logic [1:0] {
        REG_BIAS_SOURCE  = 2'd0,
        REG_GAIN_CODE    = 2'd1,
        REG_SUPPLY_VOLTS = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BIAS  = 2'd1,
        STATUS_UNITY = 2'd2,
        STATUS_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0] bias_source;
        logic [2:0] gain_code;
        logic [3:0] supply_volts;
    } cfg_t;

    // Sideband that travels with each transaction through the pipeline.
    typedef struct packed {
        status_t    status;
        logic       neg;
        logic [1:0] range_code;
    } tag_t;

    typedef logic [STEP_W-1:0] step_table_t [128];

    // Range-0 step in microvolts indexed by {gain_code, volts}; zero marks a
    // step that is not positive.
    function automatic step_table_t build_step_table();
        step_table_t tbl;
        int s;
        int d;
        int num;
        int q;
        for (int g = 0; g < 8; g++) begin
            for (int v = 0; v < 16; v++) begin
                s = BASE_STEP_UV * (v - 1);
                if (s <= 0) begin
                    tbl[g * 16 + v] = '0;
                end else if (g < 2) begin
                    tbl[g * 16 + v] = STEP_W'(s);
                end else begin
                    d = GAIN_DIV[g - 2];
                    // Rounded quotient by shift and subtract; it fits in STEP_W bits.
                    num = s * COEFF_SCALE + d / 2;
                    q = 0;
                    for (int b = STEP_W - 1; b >= 0; b--) begin
                        if (num >= (d << b)) begin
                            num = num - (d << b);
                            q = q | (1 << b);
                        end
                    end
                    tbl[g * 16 + v] = STEP_W'(q);
                end
            end
        end
        return tbl;
    endfunction

    localparam step_table_t STEP_TABLE = build_step_table();

endpackage

`default_nettype wire

@@ rtl/aoce_front.sv @@
// Front stages: step lookup, range bounds, range selection and dividend.
`default_nettype none

module aoce_front
    import aoce_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     en,
    input  wire cfg_t                     cfg,
    input  wire logic                     in_valid,
    input  wire logic signed [MAG_W-1:0]  in_request,
    output logic                          out_valid,
    output tag_t                          out_tag,
    output logic [MAG_W-1:0]              out_dividend,
    output logic [VLSB_W-1:0]             out_divisor
);

    // Stage 1: capture, magnitude, early status and step lookup.
    logic              v1_reg;
    tag_t              tag1_reg, tag1_next;
    logic [MAG_W-1:0]  mag1_reg, mag1_next;
    logic [STEP_W-1:0] step1_reg, step1_next;
    logic [3:0]        volts_sel;

    always_comb begin
        volts_sel = (cfg.bias_source == BIAS_SUPPLY) ? cfg.supply_volts : BANDGAP_VOLTS;
        step1_next = STEP_TABLE[{cfg.gain_code, volts_sel}];
        tag1_next.neg = in_request[MAG_W-1];
        tag1_next.range_code = 2'd0;
        mag1_next = in_request[MAG_W-1] ? MAG_W'(-in_request) : MAG_W'(in_request);
        if (cfg.bias_source != BIAS_BANDGAP && cfg.bias_source != BIAS_SUPPLY) begin
            tag1_next.status = STATUS_BIAS;
        end else if (cfg.gain_code == GAIN_UNITY) begin
            tag1_next.status = STATUS_UNITY;
        end else begin
            tag1_next.status = STATUS_OK;
        end
    end

    // Stage 2: step lsb of every range, step * (2^(i+1) - 1).
    logic              v2_reg;
    tag_t              tag2_reg;
    logic [MAG_W-1:0]  mag2_reg;
    logic [VLSB_W-1:0] vlsb2_reg [NUM_RANGES];
    logic [VLSB_W-1:0] vlsb2_next [NUM_RANGES];

    always_comb begin
        for (int i = 0; i < NUM_RANGES; i++) begin
            vlsb2_next[i] = (VLSB_W'(step1_reg) << (i + 1)) - VLSB_W'(step1_reg);
        end
    end

    // Stage 3: compare against 127 steps of every range, take the first fit.
    logic              v3_reg;
    tag_t              tag3_reg, tag3_next;
    logic [MAG_W-1:0]  mag3_reg;
    logic [VLSB_W-1:0] vlsb3_reg, vlsb3_next;
    logic [BOUND_W-1:0] bound [NUM_RANGES];
    logic [NUM_RANGES-1:0] fit;

    always_comb begin
        for (int i = 0; i < NUM_RANGES; i++) begin
            bound[i] = (BOUND_W'(vlsb2_reg[i]) << 7) - BOUND_W'(vlsb2_reg[i]);
            fit[i] = mag2_reg < {1'b0, bound[i]};
        end
        tag3_next = tag2_reg;
        vlsb3_next = vlsb2_reg[NUM_RANGES-1];
        for (int i = NUM_RANGES - 1; i >= 0; i--) begin
            if (fit[i]) begin
                tag3_next.range_code = 2'(i);
                vlsb3_next = vlsb2_reg[i];
            end
        end
        // A step that is not positive reads as zero and fits no range.
        if (tag2_reg.status == STATUS_OK && fit == '0) begin
            tag3_next.status = STATUS_RANGE;
        end
    end

    // Stage 4: rounding offset added to the dividend.
    logic              v4_reg;
    tag_t              tag4_reg;
    logic [MAG_W-1:0]  dvd4_reg, dvd4_next;
    logic [VLSB_W-1:0] vlsb4_reg;

    assign dvd4_next = mag3_reg + MAG_W'(vlsb3_reg >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tag1_reg  <= tag1_next;
            mag1_reg  <= mag1_next;
            step1_reg <= step1_next;
            tag2_reg  <= tag1_reg;
            mag2_reg  <= mag1_reg;
            vlsb2_reg <= vlsb2_next;
            tag3_reg  <= tag3_next;
            mag3_reg  <= mag2_reg;
            vlsb3_reg <= vlsb3_next;
            tag4_reg  <= tag3_reg;
            dvd4_reg  <= dvd4_next;
            vlsb4_reg <= vlsb3_reg;
        end
    end

    assign out_valid    = v4_reg;
    assign out_tag      = tag4_reg;
    assign out_dividend = dvd4_reg;
    assign out_divisor  = vlsb4_reg;

endmodule

`default_nettype wire

@@ rtl/aoce_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module aoce_div
    import aoce_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire tag_t              in_tag,
    input  wire logic [MAG_W-1:0]  in_dividend,
    input  wire logic [VLSB_W-1:0] in_divisor,
    output logic                   out_valid,
    output tag_t                   out_tag,
    output logic [Q_W-1:0]         out_quot,
    output logic [VLSB_W-1:0]      out_divisor
);

    logic              vld_reg  [Q_W];
    tag_t              tag_reg  [Q_W];
    logic [MAG_W-1:0]  rem_reg  [Q_W];
    logic [Q_W-1:0]    quot_reg [Q_W];
    logic [VLSB_W-1:0] dvs_reg  [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        localparam int B = Q_W - 1 - k;

        logic              v_in;
        tag_t              t_in;
        logic [MAG_W-1:0]  r_in;
        logic [Q_W-1:0]    q_in;
        logic [VLSB_W-1:0] d_in;
        logic [MAG_W:0]    shifted;
        logic [MAG_W:0]    diff;
        logic              take;
        logic [Q_W-1:0]    q_next;
        logic [MAG_W-1:0]  r_next;

        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign t_in = in_tag;
            assign r_in = in_dividend;
            assign q_in = '0;
            assign d_in = in_divisor;
        end else begin : g_rest
            assign v_in = vld_reg[k-1];
            assign t_in = tag_reg[k-1];
            assign r_in = rem_reg[k-1];
            assign q_in = quot_reg[k-1];
            assign d_in = dvs_reg[k-1];
        end

        // The remainder stays below twice the shifted divisor, so one trial
        // subtraction settles each bit.
        assign shifted = (MAG_W + 1)'(d_in) << B;
        assign diff    = {1'b0, r_in} - shifted;
        assign take    = !diff[MAG_W];
        assign q_next  = q_in | (Q_W'(take) << B);
        assign r_next  = take ? diff[MAG_W-1:0] : r_in;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                tag_reg[k]  <= t_in;
                rem_reg[k]  <= r_next;
                quot_reg[k] <= q_next;
                dvs_reg[k]  <= d_in;
            end
        end
    end

    assign out_valid   = vld_reg[Q_W-1];
    assign out_tag     = tag_reg[Q_W-1];
    assign out_quot    = quot_reg[Q_W-1];
    assign out_divisor = dvs_reg[Q_W-1];

endmodule

`default_nettype wire

@@ rtl/aoce_back.sv @@
// Back stages: applied offset product, sign and result register.
`default_nettype none

module aoce_back
    import aoce_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire tag_t              in_tag,
    input  wire logic [Q_W-1:0]    in_quot,
    input  wire logic [VLSB_W-1:0] in_divisor,
    output logic                   out_valid,
    output logic [1:0]             out_status,
    output logic [1:0]             out_range_code,
    output logic [7:0]             out_cal_code,
    output logic signed [MAG_W-1:0] out_applied_uv
);

    logic              vp_reg;
    tag_t              tagp_reg;
    logic [Q_W-1:0]    quotp_reg;
    logic [PROD_W-1:0] prodp_reg, prodp_next;

    logic              vo_reg;
    logic [1:0]        status_reg, status_next;
    logic [1:0]        range_reg, range_next;
    logic [7:0]        cal_reg, cal_next;
    logic [MAG_W-1:0]  applied_reg, applied_next;
    logic [MAG_W-1:0]  prod_ext;

    assign prodp_next = PROD_W'(in_quot) * PROD_W'(in_divisor);
    assign prod_ext   = MAG_W'(prodp_reg);

    always_comb begin
        status_next = tagp_reg.status;
        if (tagp_reg.status == STATUS_OK) begin
            range_next   = tagp_reg.range_code;
            cal_next     = {~tagp_reg.neg, quotp_reg};
            applied_next = tagp_reg.neg ? (~prod_ext + MAG_W'(1)) : prod_ext;
        end else begin
            range_next   = '0;
            cal_next     = '0;
            applied_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else if (en) begin
            vp_reg <= in_valid;
            vo_reg <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tagp_reg    <= in_tag;
            quotp_reg   <= in_quot;
            prodp_reg   <= prodp_next;
            status_reg  <= status_next;
            range_reg   <= range_next;
            cal_reg     <= cal_next;
            applied_reg <= applied_next;
        end
    end

    assign out_valid      = vo_reg;
    assign out_status     = status_reg;
    assign out_range_code = range_reg;
    assign out_cal_code   = cal_reg;
    assign out_applied_uv = applied_reg;

endmodule

`default_nettype wire

@@ rtl/amp_offset_cal_encoder_top.sv @@
// Top level of the offset calibration encoder: registers, pipeline and checks.
// Throughput: one transaction per cycle; the 13-stage pipeline, with a 7-stage
// divider at one quotient bit per stage, advances whenever the result register is free.
// Reset: synchronous active-low aresetn empties the pipeline and sets bias_source 0,
// gain_code 0 and supply_volts 5.
`default_nettype none
`include "amp_offset_cal_encoder_top_defines.svh"

module amp_offset_cal_encoder_top
    import aoce_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [3:0]           cfg_data,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [22:0]   s_request_uv,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [1:0]                m_status,
    output logic [1:0]                m_range_code,
    output logic [7:0]                m_cal_code,
    output logic signed [22:0]        m_applied_uv
);

    cfg_t cfg_reg, cfg_next;
    logic en;

    // The whole pipeline moves together while the result register can take data.
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_BIAS_SOURCE:  cfg_next.bias_source  = cfg_data[1:0];
                REG_GAIN_CODE:    cfg_next.gain_code    = cfg_data[2:0];
                REG_SUPPLY_VOLTS: cfg_next.supply_volts = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bias_source  <= 2'd0;
            cfg_reg.gain_code    <= 3'd0;
            cfg_reg.supply_volts <= 4'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    logic              f_valid;
    tag_t              f_tag;
    logic [MAG_W-1:0]  f_dividend;
    logic [VLSB_W-1:0] f_divisor;

    aoce_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .cfg          (cfg_reg),
        .in_valid     (s_valid && s_ready),
        .in_request   (s_request_uv),
        .out_valid    (f_valid),
        .out_tag      (f_tag),
        .out_dividend (f_dividend),
        .out_divisor  (f_divisor)
    );

    logic              d_valid;
    tag_t              d_tag;
    logic [Q_W-1:0]    d_quot;
    logic [VLSB_W-1:0] d_divisor;

    aoce_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (f_valid),
        .in_tag      (f_tag),
        .in_dividend (f_dividend),
        .in_divisor  (f_divisor),
        .out_valid   (d_valid),
        .out_tag     (d_tag),
        .out_quot    (d_quot),
        .out_divisor (d_divisor)
    );

    aoce_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .en             (en),
        .in_valid       (d_valid),
        .in_tag         (d_tag),
        .in_quot        (d_quot),
        .in_divisor     (d_divisor),
        .out_valid      (m_valid),
        .out_status     (m_status),
        .out_range_code (m_range_code),
        .out_cal_code   (m_cal_code),
        .out_applied_uv (m_applied_uv)
    );

    `AOCE_ASSERT_IMPLIES(a_error_zero, aclk, aresetn, m_valid && m_status != STATUS_OK, m_range_code == 2'd0 && m_cal_code == 8'd0 && m_applied_uv == 23'sd0, "error result carries nonzero fields")
    `AOCE_ASSERT_IMPLIES(a_pos_sign, aclk, aresetn, m_valid && m_status == STATUS_OK && m_cal_code[7], !m_applied_uv[22], "positive polarity with negative applied offset")
    `AOCE_ASSERT_IMPLIES(a_zero_steps, aclk, aresetn, m_valid && m_status == STATUS_OK && m_cal_code[6:0] == 7'd0, m_applied_uv == 23'sd0, "zero magnitude with nonzero applied offset")
    `AOCE_ASSERT_NEXT(a_reset_empty, aclk, !aresetn, !m_valid, "result valid right after reset")

endmodule

`default_nettype wire

@@ bench/amp_offset_cal_encoder_top_test.sv @@
// Self-checking testbench for the offset calibration encoder top level.
module amp_offset_cal_encoder_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import aoce_pkg::*;

    localparam int PIPE_LATENCY  = 13;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int LONG_HOLD     = 200;
    localparam int NUM_PHASES    = 13;
    localparam int PHASE_ITEMS   = 100;
    localparam int PRESSURE_PHASE = 2;

    localparam logic [1:0] BIAS_OFF      = 2'd0;
    localparam logic [1:0] BIAS_RESERVED = 2'd3;

    // Gain coefficients in thousandths, indexed by gain code.
    localparam int MILLI_DIVISOR [8] = '{0, 0, 1333, 2301, 4283, 8289, 16311, 31599};

    typedef struct packed {
        status_t     status;
        logic [1:0]  range_code;
        logic [7:0]  cal_code;
        logic [22:0] applied_uv;
    } cal_result_t;

    typedef struct {
        cfg_t        setting;
        logic [22:0] request;
        bit          typed;
        cal_result_t want;
    } stim_row_t;

    localparam cal_result_t UNTYPED   = '{STATUS_OK, 2'd0, 8'd0, 23'd0};
    localparam cal_result_t ERR_BIAS  = '{STATUS_BIAS, 2'd0, 8'd0, 23'd0};
    localparam cal_result_t ERR_UNITY = '{STATUS_UNITY, 2'd0, 8'd0, 23'd0};
    localparam cal_result_t ERR_RANGE = '{STATUS_RANGE, 2'd0, 8'd0, 23'd0};

    localparam cfg_t PRESETS [6] = '{
        '{BIAS_SUPPLY, 3'd7, 4'd15},
        '{BIAS_SUPPLY, 3'd1, 4'd0},
        '{BIAS_BANDGAP, 3'd2, 4'd0},
        '{BIAS_SUPPLY, 3'd4, 4'd1},
        '{BIAS_RESERVED, 3'd5, 4'd9},
        '{BIAS_SUPPLY, GAIN_UNITY, 4'd2}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [22:0] s_request_uv;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [1:0]  m_range_code;
    logic [7:0]  m_cal_code;
    logic [22:0] m_applied_uv;

    cfg_t        setting;
    cal_result_t calibrations_due [$];
    int          mismatches = 0;
    int          requests_sent = 0;
    int          settings_used = 0;
    int          status_hits [4] = '{0, 0, 0, 0};
    int          range_hits [4] = '{0, 0, 0, 0};
    int          holds_asked = 0;
    int          holds_done = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_stalls = 1'b1;

    // Rows marked typed carry a result that follows directly from the special cases.
    stim_row_t directed_rows [24] = '{
        '{'{BIAS_OFF, GAIN_UNITY, 4'd5}, 23'd0, 1'b1, ERR_BIAS},
        '{'{BIAS_RESERVED, GAIN_UNITY, 4'd5}, 23'd100, 1'b1, ERR_BIAS},
        '{'{BIAS_RESERVED, 3'd4, 4'd5}, -23'sd100, 1'b1, ERR_BIAS},
        '{'{BIAS_SUPPLY, GAIN_UNITY, 4'd5}, 23'd100, 1'b1, ERR_UNITY},
        '{'{BIAS_BANDGAP, GAIN_UNITY, 4'd5}, 23'h3FFFFF, 1'b1, ERR_UNITY},
        '{'{BIAS_SUPPLY, 3'd1, 4'd5}, 23'd0, 1'b1, '{STATUS_OK, 2'd0, 8'h80, 23'd0}},
        '{'{BIAS_SUPPLY, 3'd1, 4'd5}, 23'd504, 1'b1, '{STATUS_OK, 2'd0, 8'h81, 23'd504}},
        '{'{BIAS_SUPPLY, 3'd1, 4'd5}, -23'sd504, 1'b1,
          '{STATUS_OK, 2'd0, 8'h01, -23'sd504}},
        '{'{BIAS_SUPPLY, 3'd1, 4'd5}, 23'h3FFFFF, 1'b1, ERR_RANGE},
        '{'{BIAS_SUPPLY, 3'd1, 4'd5}, 23'h400000, 1'b1, ERR_RANGE},
        '{'{BIAS_SUPPLY, 3'd1, 4'd0}, 23'd0, 1'b1, ERR_RANGE},
        '{'{BIAS_SUPPLY, 3'd1, 4'd1}, 23'd5, 1'b1, ERR_RANGE},
        '{'{BIAS_SUPPLY, 3'd7, 4'd1}, 23'd0, 1'b1, ERR_RANGE},
        '{'{BIAS_SUPPLY, 3'd1, 4'd15}, 23'd3360419, 1'b0, UNTYPED},
        '{'{BIAS_SUPPLY, 3'd1, 4'd15}, -23'sd3360420, 1'b0, UNTYPED},
        '{'{BIAS_SUPPLY, 3'd1, 4'd15}, 23'd224027, 1'b0, UNTYPED},
        '{'{BIAS_SUPPLY, 3'd1, 4'd15}, 23'd224028, 1'b0, UNTYPED},
        '{'{BIAS_BANDGAP, 3'd1, 4'd15}, 23'd64007, 1'b0, UNTYPED},
        '{'{BIAS_BANDGAP, 3'd2, 4'd15}, -23'sd12345, 1'b0, UNTYPED},
        '{'{BIAS_BANDGAP, 3'd3, 4'd0}, 23'd777, 1'b0, UNTYPED},
        '{'{BIAS_BANDGAP, 3'd4, 4'd0}, -23'sd3000, 1'b0, UNTYPED},
        '{'{BIAS_SUPPLY, 3'd5, 4'd9}, 23'd100000, 1'b0, UNTYPED},
        '{'{BIAS_SUPPLY, 3'd6, 4'd15}, -23'sd51, 1'b0, UNTYPED},
        '{'{BIAS_SUPPLY, 3'd7, 4'd15}, 23'h155555, 1'b0, UNTYPED}
    };

    amp_offset_cal_encoder_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_request_uv (s_request_uv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_range_code (m_range_code),
        .m_cal_code   (m_cal_code),
        .m_applied_uv (m_applied_uv)
    );

    // Range-0 step in microvolts; zero or negative when the supply is too low.
    function automatic int range0_step(cfg_t c);
        int volts;
        int step;
        volts = (c.bias_source == BIAS_SUPPLY) ? int'(c.supply_volts) : int'(BANDGAP_VOLTS);
        step = 126 * (volts - 1);
        if (c.gain_code >= 3'd2 && step > 0) begin
            step = (step * 1000 + MILLI_DIVISOR[c.gain_code] / 2) / MILLI_DIVISOR[c.gain_code];
        end
        return step;
    endfunction

    function automatic cal_result_t encode_offset(cfg_t c, logic signed [22:0] req);
        cal_result_t r;
        int mag;
        int step;
        int lsb;
        int rng;
        int mult;
        int steps;
        int applied;
        int i;
        r = UNTYPED;
        mag = (req < 0) ? -int'(req) : int'(req);
        lsb = 0;
        rng = 0;
        if (c.bias_source != BIAS_BANDGAP && c.bias_source != BIAS_SUPPLY) begin
            r.status = STATUS_BIAS;
        end else if (c.gain_code == GAIN_UNITY) begin
            r.status = STATUS_UNITY;
        end else begin
            step = range0_step(c);
            if (step > 0) begin
                for (i = 0; i < 4; i++) begin
                    mult = (2 << i) - 1;
                    if (lsb == 0 && mag < step * 127 * mult) begin
                        lsb = step * mult;
                        rng = i;
                    end
                end
            end
            if (lsb <= 0) begin
                r.status = STATUS_RANGE;
            end else begin
                steps = ((mag + lsb / 2) / lsb) & 127;
                applied = (req < 0) ? -(steps * lsb) : steps * lsb;
                r.range_code = rng[1:0];
                r.cal_code = {(req >= 0), steps[6:0]};
                r.applied_uv = applied[22:0];
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        if ($urandom_range(0, 9) < 7) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Most requests land inside a range or right at a range bound for the current step.
    function automatic logic [22:0] pick_request(cfg_t c);
        int step;
        int sel;
        int bound;
        int mag;
        step = range0_step(c);
        sel = $urandom_range(0, 9);
        if (step <= 0 || sel < 2) begin
            return 23'($urandom);
        end
        bound = step * 127 * ((2 << $urandom_range(0, 3)) - 1);
        if (sel < 5) begin
            mag = bound - step + $urandom_range(0, 2 * step);
        end else begin
            mag = $urandom_range(0, bound);
        end
        return ($urandom_range(0, 1) == 1) ? 23'(-mag) : 23'(mag);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] error: %s", $time, what);
        mismatches++;
    endtask

    task automatic write_reg(reg_index_t idx, logic [3:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BIAS_SOURCE:  setting.bias_source  = data[1:0];
            REG_GAIN_CODE:    setting.gain_code    = data[2:0];
            REG_SUPPLY_VOLTS: setting.supply_volts = data;
            default: ;
        endcase
    endtask

    // Unused upper data bits are randomized; the block must ignore them.
    task automatic set_config(cfg_t want, bit write_all);
        bit wrote;
        wrote = 1'b0;
        if (write_all || want.bias_source != setting.bias_source) begin
            write_reg(REG_BIAS_SOURCE, {2'($urandom), want.bias_source});
            wrote = 1'b1;
        end
        if (write_all || want.gain_code != setting.gain_code) begin
            write_reg(REG_GAIN_CODE, {1'($urandom), want.gain_code});
            wrote = 1'b1;
        end
        if (write_all || want.supply_volts != setting.supply_volts) begin
            write_reg(REG_SUPPLY_VOLTS, want.supply_volts);
            wrote = 1'b1;
        end
        if (wrote) begin
            @(negedge aclk) cfg_valid <= 1'b0;
        end
        settings_used++;
    endtask

    task automatic offer(logic [22:0] req, bit typed, cal_result_t want);
        int gap;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_request_uv <= req;
        do @(posedge aclk); while (!s_ready);
        calibrations_due.push_back(typed ? want : encode_offset(setting, req));
        requests_sent++;
        if (tx_gaps && $urandom_range(0, 2) == 0) begin
            gap = gap_length();
            @(negedge aclk) s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stop offering, wait for every outstanding result, then let the pipeline empty.
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge aclk) s_valid <= 1'b0;
        while (calibrations_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (calibrations_due.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      calibrations_due.size()));
            calibrations_due.delete();
        end
        repeat (PIPE_LATENCY + 2) @(posedge aclk);
    endtask

    initial begin : clock_gen
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Run timed out with %0d results outstanding.", calibrations_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holds_done != holds_asked) begin
                holds_done = holds_asked;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && rx_stalls && $urandom_range(0, 3) == 0) begin
                stall_left = gap_length();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_results
        cal_result_t want;
        if (aresetn && m_valid && m_ready) begin
            status_hits[m_status]++;
            if (m_status == STATUS_OK) begin
                range_hits[m_range_code]++;
            end
            if (calibrations_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result, status %0d", m_status));
            end else begin
                want = calibrations_due.pop_front();
                if (m_status !== want.status) begin
                    report_mismatch($sformatf("status %0d, expected %0d", m_status, want.status));
                end
                if (m_range_code !== want.range_code) begin
                    report_mismatch($sformatf("range_code %0d, expected %0d",
                                              m_range_code, want.range_code));
                end
                if (m_cal_code !== want.cal_code) begin
                    report_mismatch($sformatf("cal_code 0x%02h, expected 0x%02h",
                                              m_cal_code, want.cal_code));
                end
                if (m_applied_uv !== want.applied_uv) begin
                    report_mismatch($sformatf("applied_uv %0d, expected %0d",
                                              $signed(m_applied_uv), $signed(want.applied_uv)));
                end
            end
        end
    end

    initial begin : stimulus
        cfg_t next_cfg;
        int r;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_BIAS_SOURCE;
        cfg_data     = 4'd0;
        s_valid      = 1'b0;
        s_request_uv = 23'd0;
        // Register values after reset.
        setting = '{BIAS_OFF, GAIN_UNITY, 4'd5};
        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].setting != setting) begin
                settle();
                set_config(directed_rows[i].setting, 1'b0);
            end
            offer(directed_rows[i].request, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p < $size(PRESETS)) begin
                next_cfg = PRESETS[p];
            end else begin
                r = $urandom_range(0, 9);
                next_cfg.bias_source = (r < 1) ? BIAS_OFF : (r < 2) ? BIAS_RESERVED :
                                       (r < 6) ? BIAS_SUPPLY : BIAS_BANDGAP;
                next_cfg.gain_code = ($urandom_range(0, 9) == 0) ? GAIN_UNITY
                                                                 : 3'($urandom_range(1, 7));
                next_cfg.supply_volts = 4'($urandom);
            end
            set_config(next_cfg, 1'b1);
            if (p == PRESSURE_PHASE) begin
                // Back-to-back requests against a long output stall fill the pipeline.
                tx_gaps   = 1'b0;
                rx_stalls = 1'b1;
                holds_asked++;
            end else begin
                tx_gaps   = ($urandom_range(0, 3) != 0);
                rx_stalls = tx_gaps;
            end
            repeat (PHASE_ITEMS) offer(pick_request(setting), 1'b0, UNTYPED);
        end

        settle();
        $display("Covered %0d requests over %0d register settings, with one long output stall.",
                 requests_sent, settings_used);
        $display("Results ok/bias/unity/range: %0d/%0d/%0d/%0d; ok by range 0-3: %0d/%0d/%0d/%0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 range_hits[0], range_hits[1], range_hits[2], range_hits[3]);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
